// ===== hw/rtl/sefr_pkg.sv =====
`default_nettype none

package sefr_pkg;

	// Frame phase, one-hot
	typedef enum logic [4:0] {
		PH_HUNT   = 5'b00001,
		PH_HEADER = 5'b00010,
		PH_DATA   = 5'b00100,
		PH_CHECK  = 5'b01000,
		PH_END    = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_SOF = 2'd1,
		ST_EOF = 2'd2,
		ST_CHK = 2'd3
	} status_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_START_BYTE   = 2'd0,
		CFG_END_BYTE     = 2'd1,
		CFG_MAX_UNFRAMED = 2'd2
	} cfg_idx_t;

	localparam int unsigned CFG_DATA_W = 16;

	// One result word
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       in_header;
		logic       frame_done;
		status_t    status;
	} result_t;

	// Deframer to output queue
	typedef struct packed {
		logic    push;
		result_t res;
	} push_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sefr_deframer.sv =====
`default_nettype none

module sefr_deframer #(
	parameter int unsigned HEADER_BYTES = 4
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              step,
	input  wire logic                              func,
	input  wire logic [7:0]                        rx_byte,
	input  wire logic                              cfg_we,
	input  wire logic [1:0]                        cfg_index,
	input  wire logic [sefr_pkg::CFG_DATA_W-1:0]   cfg_data,
	output sefr_pkg::push_t                        push_o
);

	localparam logic [16:0] HDR_LEN = 17'(HEADER_BYTES);

	logic [7:0]  start_byte_q, end_byte_q;
	logic [15:0] max_unframed_q;

	sefr_pkg::phase_t phase_q, phase_d;
	logic [15:0] cnt_q, cnt_d;
	logic [15:0] dlen_q, dlen_d;
	logic [7:0]  xor_q, xor_d;
	logic [7:0]  chk_q, chk_d;
	logic [15:0] unf_q, unf_d;

	logic [16:0] cnt_inc;
	logic [15:0] unf_inc;
	logic [7:0]  xor_new;
	sefr_pkg::push_t push_d;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q   <= 8'd126;
			end_byte_q     <= 8'd127;
			max_unframed_q <= 16'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sefr_pkg::CFG_START_BYTE:   start_byte_q   <= cfg_data[7:0];
				sefr_pkg::CFG_END_BYTE:     end_byte_q     <= cfg_data[7:0];
				sefr_pkg::CFG_MAX_UNFRAMED: max_unframed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cnt_inc = {1'b0, cnt_q} + 17'd1;
	assign unf_inc = (unf_q == 16'hFFFF) ? unf_q : unf_q + 16'd1;
	assign xor_new = xor_q ^ rx_byte;

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		dlen_d  = dlen_q;
		xor_d   = xor_q;
		chk_d   = chk_q;
		unf_d   = unf_q;
		push_d  = '0;
		push_d.res.status = sefr_pkg::ST_OK;
		if (func) begin
			phase_d = sefr_pkg::PH_HUNT;
			cnt_d   = '0;
			dlen_d  = '0;
			xor_d   = '0;
			chk_d   = '0;
		end else begin
			unique case (phase_q)
				sefr_pkg::PH_HEADER: begin
					xor_d = xor_new;
					if (cnt_q == 16'd0)
						dlen_d = {dlen_q[15:8], rx_byte};
					else if (cnt_q == 16'd1)
						dlen_d = {rx_byte, dlen_q[7:0]};
					if (cnt_inc >= HDR_LEN) begin
						cnt_d   = '0;
						phase_d = (dlen_d == 16'd0) ? sefr_pkg::PH_CHECK
							: sefr_pkg::PH_DATA;
					end else begin
						cnt_d = cnt_inc[15:0];
					end
					push_d.push           = 1'b1;
					push_d.res.data_byte  = rx_byte;
					push_d.res.byte_valid = 1'b1;
					push_d.res.in_header  = 1'b1;
				end
				sefr_pkg::PH_DATA: begin
					xor_d = xor_new;
					if (cnt_inc >= {1'b0, dlen_q}) begin
						cnt_d   = '0;
						phase_d = sefr_pkg::PH_CHECK;
					end else begin
						cnt_d = cnt_inc[15:0];
					end
					push_d.push           = 1'b1;
					push_d.res.data_byte  = rx_byte;
					push_d.res.byte_valid = 1'b1;
				end
				sefr_pkg::PH_CHECK: begin
					chk_d   = rx_byte;
					phase_d = sefr_pkg::PH_END;
				end
				sefr_pkg::PH_END: begin
					// wrong end byte wins over a checksum mismatch
					if (rx_byte != end_byte_q)
						push_d.res.status = sefr_pkg::ST_EOF;
					else if (chk_q != xor_q)
						push_d.res.status = sefr_pkg::ST_CHK;
					push_d.push           = 1'b1;
					push_d.res.frame_done = 1'b1;
					phase_d = sefr_pkg::PH_HUNT;
					cnt_d   = '0;
					dlen_d  = '0;
					xor_d   = '0;
					chk_d   = '0;
				end
				default: begin
					// hunting, also any stray phase code
					phase_d = sefr_pkg::PH_HUNT;
					if (rx_byte == start_byte_q) begin
						unf_d   = '0;
						cnt_d   = '0;
						dlen_d  = '0;
						xor_d   = '0;
						chk_d   = '0;
						phase_d = sefr_pkg::PH_HEADER;
					end else if (unf_inc > max_unframed_q) begin
						unf_d                 = '0;
						push_d.push           = 1'b1;
						push_d.res.frame_done = 1'b1;
						push_d.res.status     = sefr_pkg::ST_SOF;
					end else begin
						unf_d = unf_inc;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sefr_pkg::PH_HUNT;
			cnt_q   <= '0;
			dlen_q  <= '0;
			xor_q   <= '0;
			chk_q   <= '0;
			unf_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			dlen_q  <= dlen_d;
			xor_q   <= xor_d;
			chk_q   <= chk_d;
			unf_q   <= unf_d;
		end
	end

	always_comb begin
		push_o      = push_d;
		push_o.push = push_d.push & step;
	end

	a_clear_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		step && func |=> phase_q == sefr_pkg::PH_HUNT && xor_q == 8'd0)
		else $error("clear did not return to hunting");

	a_end_reports: assert property (@(posedge clk) disable iff (!arst_n)
		step && !func && phase_q == sefr_pkg::PH_END
		|-> push_o.push && push_o.res.frame_done)
		else $error("end byte without frame report");

endmodule

`default_nettype wire

// ===== hw/rtl/sefr_out_queue.sv =====
`default_nettype none

module sefr_out_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sefr_pkg::push_t  push_i,
	input  wire logic             pop,
	output logic                  full,
	output logic                  out_valid,
	output sefr_pkg::result_t     head
);

	sefr_pkg::result_t entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_pop;

	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign head      = entry_q[rd_ptr_q];
	assign do_pop    = pop & out_valid;

	always_ff @(posedge clk) begin
		if (push_i.push)
			entry_q[wr_ptr_q] <= push_i.res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push_i.push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push_i.push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push_i.push && full))
		else $error("push into full result queue");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		!push_i.push && do_pop |=> count_q == $past(count_q) - 2'd1)
		else $error("queue count lost a pop");

endmodule

`default_nettype wire

// ===== hw/rtl/sof_eof_frame_receiver_top.sv =====
`default_nettype none

// Channel  Direction  Handshake          Payload
// in       sink       in_valid/in_stall  func, rx_byte
// out      source     out_valid/out_stall data_byte, byte_valid, in_header,
//                                        frame_done, status
// cfg      sink       cfg_we             cfg_index, cfg_data (no read-back)
//
// One input word per cycle while in_stall is low: the frame state updates in the
// cycle the word is accepted and its result (if any) lands in a two-entry output
// queue, which raises out_valid for it from the next cycle.
// in_stall rises only when the output queue holds two results, i.e. after the
// consumer has stalled out for a while; it comes straight from the queue count.
// Reset (arst_n low) puts the deframer in hunting, empties the queue and
// loads start 0x7E, end 0x7F, unframed limit 64.

module sof_eof_frame_receiver_top #(
	parameter int unsigned HEADER_BYTES = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input words
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [7:0]  rx_byte,
	// results
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       data_byte,
	output logic             byte_valid,
	output logic             in_header,
	output logic             frame_done,
	output logic [1:0]       status,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [sefr_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic              step;
	logic              q_full;
	sefr_pkg::push_t   push;
	sefr_pkg::result_t head;

	// a word is taken whenever the queue has room for its result
	assign in_stall = q_full;
	assign step     = in_valid & ~q_full;

	sefr_deframer #(
		.HEADER_BYTES (HEADER_BYTES)
	) u_deframer (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.func      (func),
		.rx_byte   (rx_byte),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push_o    (push)
	);

	sefr_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_i    (push),
		.pop       (~out_stall),
		.full      (q_full),
		.out_valid (out_valid),
		.head      (head)
	);

	assign data_byte  = head.data_byte;
	assign byte_valid = head.byte_valid;
	assign in_header  = head.in_header;
	assign frame_done = head.frame_done;
	assign status     = head.status;

endmodule

`default_nettype wire

// ===== tb/sof_eof_frame_receiver_checker.sv =====
`default_nettype none

module sof_eof_frame_receiver_checker #(
	parameter int unsigned HEADER_BYTES = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic        func,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_valid,
	input  wire logic        in_header,
	input  wire logic        frame_done,
	input  wire logic [1:0]  status,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [sefr_pkg::CFG_DATA_W-1:0] cfg_data,
	output int               results_owed,
	output int               mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRINT_CAP = 40;

	// register copies
	logic [7:0]  sof_val;
	logic [7:0]  eof_val;
	logic [15:0] drop_limit;

	// deframer state
	sefr_pkg::phase_t fr_phase;
	logic [15:0] hdr_cnt;
	logic [15:0] frame_len;
	logic [7:0]  sum_xor;
	logic [7:0]  got_check;
	logic [15:0] dropped;

	sefr_pkg::result_t frame_results_q[$];
	int          results_seen;

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_CAP)
			$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got %0h want %0h",
				results_seen, name, got, want));
	endtask

	function automatic void drop_frame();
		fr_phase  = sefr_pkg::PH_HUNT;
		hdr_cnt   = '0;
		frame_len = '0;
		sum_xor   = '0;
		got_check = '0;
	endfunction

	// one accepted word in, zero or one result out
	function automatic bit deframe_word(input logic clr, input logic [7:0] b,
			output sefr_pkg::result_t r);
		r = '0;
		if (clr) begin
			drop_frame();
			return 1'b0;
		end
		case (fr_phase)
		sefr_pkg::PH_HEADER: begin
			sum_xor ^= b;
			if (hdr_cnt == 16'd0)
				frame_len[7:0] = b;
			else if (hdr_cnt == 16'd1)
				frame_len[15:8] = b;
			hdr_cnt++;
			if (hdr_cnt >= HEADER_BYTES) begin
				hdr_cnt  = '0;
				fr_phase = (frame_len == 16'd0) ? sefr_pkg::PH_CHECK
					: sefr_pkg::PH_DATA;
			end
			r.data_byte  = b;
			r.byte_valid = 1'b1;
			r.in_header  = 1'b1;
			r.status     = sefr_pkg::ST_OK;
			return 1'b1;
		end
		sefr_pkg::PH_DATA: begin
			sum_xor ^= b;
			hdr_cnt++;
			if (hdr_cnt >= frame_len) begin
				hdr_cnt  = '0;
				fr_phase = sefr_pkg::PH_CHECK;
			end
			r.data_byte  = b;
			r.byte_valid = 1'b1;
			r.status     = sefr_pkg::ST_OK;
			return 1'b1;
		end
		sefr_pkg::PH_CHECK: begin
			got_check = b;
			fr_phase  = sefr_pkg::PH_END;
			return 1'b0;
		end
		sefr_pkg::PH_END: begin
			// a bad end byte wins over a bad checksum
			if (b != eof_val)
				r.status = sefr_pkg::ST_EOF;
			else if (got_check != sum_xor)
				r.status = sefr_pkg::ST_CHK;
			else
				r.status = sefr_pkg::ST_OK;
			drop_frame();
			r.frame_done = 1'b1;
			return 1'b1;
		end
		default: begin
			fr_phase = sefr_pkg::PH_HUNT;
			if (b == sof_val) begin
				dropped = '0;
				drop_frame();
				fr_phase = sefr_pkg::PH_HEADER;
				return 1'b0;
			end
			if (dropped != 16'hFFFF)
				dropped++;
			if (dropped > drop_limit) begin
				dropped      = '0;
				r.frame_done = 1'b1;
				r.status     = sefr_pkg::ST_SOF;
				return 1'b1;
			end
			return 1'b0;
		end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sefr_pkg::result_t want;
		bit      has_res;
		if (!arst_n) begin
			sof_val    = 8'h7E;
			eof_val    = 8'h7F;
			drop_limit = 16'd64;
			drop_frame();
			dropped    = '0;
			frame_results_q.delete();
			results_seen = 0;
			mismatches   = 0;
			results_owed <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				sefr_pkg::CFG_START_BYTE:   sof_val    = cfg_data[7:0];
				sefr_pkg::CFG_END_BYTE:     eof_val    = cfg_data[7:0];
				sefr_pkg::CFG_MAX_UNFRAMED: drop_limit = cfg_data[15:0];
				default: ;
				endcase
			end
			// predict first: a result never leaves the queue in the cycle its word is accepted
			if (in_valid && !in_stall) begin
				has_res = deframe_word(func, rx_byte, want);
				if (has_res)
					frame_results_q.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (frame_results_q.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with none expected",
						results_seen));
				end else begin
					want = frame_results_q.pop_front();
					check_field("data_byte", data_byte, want.data_byte);
					check_field("byte_valid", 8'(byte_valid), 8'(want.byte_valid));
					check_field("in_header", 8'(in_header), 8'(want.in_header));
					check_field("frame_done", 8'(frame_done), 8'(want.frame_done));
					check_field("status", 8'(status), 8'(want.status));
				end
				results_seen++;
			end
			results_owed <= frame_results_q.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/sof_eof_frame_receiver_top_tb.sv =====
`default_nettype none

module sof_eof_frame_receiver_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HDR_BYTES     = 4;
	localparam int CYCLE_LIMIT   = 600000;  // far above the slowest legal run
	localparam int SETTLE_CYCLES = 8;       // margin after the last expected result
	localparam int PHASES        = 8;
	localparam int PHASE_WORDS   = 135;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        func;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  data_byte;
	logic        byte_valid;
	logic        in_header;
	logic        frame_done;
	logic [1:0]  status;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [sefr_pkg::CFG_DATA_W-1:0] cfg_data;

	int          results_owed;
	int          fail_total;
	int          items_sent;
	int          cycle_cnt;
	bit          calm_in;      // no input gaps while set

	// stimulus-side copy of the framing bytes, to build frames
	logic [7:0]  sof_val;
	logic [7:0]  eof_val;

	sof_eof_frame_receiver_top #(
		.HEADER_BYTES(HDR_BYTES)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_byte  (data_byte),
		.byte_valid (byte_valid),
		.in_header  (in_header),
		.frame_done (frame_done),
		.status     (status),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	sof_eof_frame_receiver_checker #(
		.HEADER_BYTES(HDR_BYTES)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.data_byte    (data_byte),
		.byte_valid   (byte_valid),
		.in_header    (in_header),
		.frame_done   (frame_done),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.results_owed (results_owed),
		.mismatches   (fail_total)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends here.
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("** sof_eof_frame_receiver_top: FAILED **");
		$finish;
	end

	// Result-side backpressure. Mix of calm stretches (never stalled), short
	// flickers and the odd long stall that fills the two-entry output queue
	// and pushes back onto in_stall.
	initial begin
		int hold;
		hold = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
			end else begin
				case ($urandom_range(0, 9))
				0: begin
					out_stall <= 1'b0;
					hold = $urandom_range(20, 80);
				end
				1, 2, 3, 4: begin
					out_stall <= 1'b0;
					hold = $urandom_range(0, 2);
				end
				9: begin
					out_stall <= 1'b1;
					hold = $urandom_range(8, 40);
				end
				default: begin
					out_stall <= 1'b1;
					hold = $urandom_range(0, 2);
				end
				endcase
			end
		end
	end

	// Idle cycles before a word: mostly none or a few, now and then a long gap.
	function automatic int pick_gap();
		int r;
		if (calm_in)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// Present one word and hold it until it is taken (valid high, stall low).
	// Valid stays high into the next word when there is no gap, so it gets
	// only one assignment per step.
	task automatic send_word(input logic f, input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	// Sender goes quiet until the checker holds no open expectations, then
	// a few more cycles so a word that makes no result is also done.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Block must be idle here; all three registers every time.
	task automatic load_regs(input logic [7:0] s, input logic [7:0] e,
			input logic [15:0] lim);
		cfg_we    <= 1'b1;
		cfg_index <= sefr_pkg::CFG_START_BYTE;
		cfg_data  <= {8'h00, s};
		@(posedge clk);
		cfg_index <= sefr_pkg::CFG_END_BYTE;
		cfg_data  <= {8'h00, e};
		@(posedge clk);
		cfg_index <= sefr_pkg::CFG_MAX_UNFRAMED;
		cfg_data  <= lim;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sof_val = s;
		eof_val = e;
	endtask

	// Frame on the wire: start, header (length low, length high, h2, h3, ...),
	// len data words, checksum, end. Optional flaws: wrong checksum, wrong end
	// byte, or a clear word replacing word number cut_at (-1 = no cut).
	task automatic send_frame(input logic [15:0] len, input logic [7:0] h2,
			input logic [7:0] h3, input bit bad_sum, input bit bad_end,
			input int cut_at);
		logic [7:0] b;
		logic [7:0] sum;
		int         total;
		int         k;
		sum   = '0;
		total = HDR_BYTES + int'(len) + 3;
		for (k = 0; k < total; k++) begin
			if (k == cut_at) begin
				send_word(1'b1, 8'($urandom_range(0, 255)));
				return;
			end
			if (k == 0)
				b = sof_val;
			else if (k == 1)
				b = len[7:0];
			else if (k == 2)
				b = len[15:8];
			else if (k == 3)
				b = h2;
			else if (k == 4)
				b = h3;
			else if (k < total - 2)
				b = 8'($urandom_range(0, 255));
			else if (k == total - 2)
				b = bad_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum;
			else
				b = bad_end ? (eof_val ^ 8'($urandom_range(1, 255))) : eof_val;
			if (k >= 1 && k < total - 2)
				sum ^= b;
			send_word(1'b0, b);
		end
	endtask

	// Unframed bytes. A stray start byte may open a frame with a garbage
	// length, so follow with a clear in that case to get back to hunting.
	task automatic send_noise(input int n);
		logic [7:0] b;
		bit         opened;
		opened = 1'b0;
		repeat (n) begin
			b = 8'($urandom_range(0, 255));
			if (b == sof_val)
				opened = 1'b1;
			send_word(1'b0, b);
		end
		if (opened || $urandom_range(0, 2) == 0)
			send_word(1'b1, 8'($urandom_range(0, 255)));
	endtask

	// Mostly frames with random content, some of them flawed; the rest is
	// unframed noise, clears and pauses to settle.
	task automatic run_random(input int n_words);
		int stop_at;
		int r;
		int flaw;
		int len;
		stop_at = items_sent + n_words;
		while (items_sent < stop_at) begin
			calm_in = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 99);
			if (r < 70) begin
				// mostly short frames, a rare long one
				len = ($urandom_range(0, 29) == 0) ? $urandom_range(13, 200)
					: $urandom_range(0, 12);
				flaw = $urandom_range(0, 9);
				send_frame(len[15:0], 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)),
					flaw == 7 || flaw == 9, flaw == 8 || flaw == 9,
					(flaw == 6) ? $urandom_range(0, HDR_BYTES + len + 2) : -1);
			end else if (r < 90) begin
				// long runs needed to trip a limit of 64
				send_noise(($urandom_range(0, 7) == 0) ? $urandom_range(20, 90)
					: $urandom_range(1, 6));
			end else if (r < 97) begin
				send_word(1'b1, 8'($urandom_range(0, 255)));
			end else begin
				settle();
			end
		end
		calm_in = 1'b0;
	endtask

	initial begin
		int          p;
		logic [7:0]  s;
		logic [7:0]  e;
		logic [15:0] lim;

		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		func       <= 1'b0;
		rx_byte    <= 8'h00;
		cfg_we     <= 1'b0;
		cfg_index  <= sefr_pkg::CFG_START_BYTE;
		cfg_data   <= '0;
		items_sent = 0;
		calm_in    = 1'b0;
		sof_val    = 8'h7E;
		eof_val    = 8'h7F;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset register values.
		// zero length: checksum right after header, header at the extremes
		send_frame(16'h0000, 8'hFF, 8'h80, 1'b0, 1'b0, -1);
		// one data word, checksum off
		send_frame(16'h0001, 8'h00, 8'hFF, 1'b1, 1'b0, -1);
		// end byte and checksum both wrong: end error reported
		send_frame(16'h0000, 8'h55, 8'hAA, 1'b1, 1'b1, -1);
		// max length, aborted by a clear two words into the data
		send_frame(16'hFFFF, 8'h01, 8'hFE, 1'b0, 1'b0, HDR_BYTES + 3);
		// clear while already hunting
		send_word(1'b1, 8'hFF);
		send_word(1'b0, 8'h00);

		// Register settings per phase: extremes and directed values first, then random.
		// limit 0 reports every dropped byte, 65535 never does.
		for (p = 0; p < PHASES; p++) begin
			case (p)
			0: begin s = 8'h00; e = 8'hFF; lim = 16'd0;     end
			1: begin s = 8'hFF; e = 8'h00; lim = 16'hFFFF;  end
			2: begin s = 8'h7E; e = 8'h7F; lim = 16'd3;     end
			3: begin s = 8'hA5; e = 8'hA5; lim = 16'd1;     end
			4: begin s = 8'h7E; e = 8'h7F; lim = 16'd64;    end
			default: begin
				s   = 8'($urandom_range(0, 255));
				e   = 8'($urandom_range(0, 255));
				lim = 16'($urandom_range(0, 12));
			end
			endcase
			settle();
			load_regs(s, e, lim);
			run_random(PHASE_WORDS);
		end

		settle();
		if (fail_total == 0)
			$display("** sof_eof_frame_receiver_top: PASSED **");
		else
			$display("** sof_eof_frame_receiver_top: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
